### design/rol_pkg.sv
// ----------------------------------------------------------------------------
// rol_pkg
// Types and constants shared by the recency-ordered identifier list.
// ----------------------------------------------------------------------------
package rol_pkg;

	localparam int DEPTH_DEF   = 16;
	localparam int ID_BITS_DEF = 16;
	localparam int ID_W        = 16;
	localparam int LIST_MAX    = 16;

	typedef enum logic [1:0] {
		MODE_TOUCH  = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_LIST   = 2'd2
	} rol_mode_t;

	typedef enum logic [2:0] {
		STAT_INSERTED  = 3'd0,
		STAT_MOVED     = 3'd1,
		STAT_DELETED   = 3'd2,
		STAT_NOT_FOUND = 3'd3,
		STAT_FULL      = 3'd4,
		STAT_ENTRY     = 3'd5
	} rol_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SH_RD,
		ST_SH_WR,
		ST_RESP,
		ST_LIST_RD,
		ST_LIST_EM
	} rol_state_t;

	typedef struct packed {
		rol_mode_t         mode;
		logic [ID_W-1:0]   chat_id;
	} rol_req_t;

	typedef struct packed {
		rol_status_t       status;
		logic [ID_W-1:0]   entry_id;
		logic [3:0]        rank;
		logic [4:0]        entry_count;
		logic              last;
	} rol_rsp_t;

endpackage

### design/recency_ordered_id_list.sv
// ----------------------------------------------------------------------------
// recency_ordered_id_list
// Most-recent-first list of identifiers with touch, delete and list requests.
//
//   channel | direction | word      | handshake
//   req     | in        | rol_req_t | req_valid / req_stall
//   rsp     | out       | rol_rsp_t | rsp_valid / rsp_stall
//
// Touch/delete: the scan reads entries in order up to the match, then a hit or an
// insert moves entries by a read and a write each, with a closing step (the front
// write on a touch) and a load of the result. List: each entry is read, then sent.
// Reset clears the sequencer and the entry count; the store needs no clearing pass.
// req_stall is high while a request is in progress; rsp_stall holds the
// result register and pauses the sequencer.
// ----------------------------------------------------------------------------
module recency_ordered_id_list #(
	parameter int DEPTH   = rol_pkg::DEPTH_DEF,
	parameter int ID_BITS = rol_pkg::ID_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  rol_pkg::rol_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rol_pkg::rol_rsp_t rsp
);

	import rol_pkg::*;

	localparam int AW  = $clog2(DEPTH);
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int IDW = (ID_BITS < ID_W) ? ID_BITS : ID_W;

	rol_state_t    state_q, state_d;
	logic [CW-1:0] held_q, held_d;
	logic          chk_q, chk_d;
	logic          rsp_valid_q, rsp_valid_d;

	rol_mode_t     mode_q, mode_d;
	logic [IDW-1:0] id_q, id_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] chk_idx_q, chk_idx_d;
	logic [CW-1:0] dst_q, dst_d;
	logic [CW-1:0] pos_q, pos_d;
	logic          front_q, front_d;
	rol_status_t   stat_q, stat_d;
	rol_rsp_t      rsp_q, rsp_d;
	logic          rsp_load;

	logic           wr_en, rd_en;
	logic [AW-1:0]  wr_addr, rd_addr;
	logic [IDW-1:0] wr_data, rd_data;

	logic           out_free;
	logic           match;
	logic [CW-1:0]  list_n;
	logic           list_last;

	rol_mem #(
		.DEPTH (DEPTH),
		.WIDTH (IDW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign match     = chk_q && (rd_data == id_q);
	assign list_n    = (32'(held_q) > LIST_MAX) ? CW'(LIST_MAX) : held_q;
	assign list_last = ((idx_q + 1'b1) == list_n);

	always_comb begin
		state_d     = state_q;
		held_d      = held_q;
		chk_d       = chk_q;
		mode_d      = mode_q;
		id_d        = id_q;
		idx_d       = idx_q;
		chk_idx_d   = chk_idx_q;
		dst_d       = dst_q;
		pos_d       = pos_q;
		front_d     = front_q;
		stat_d      = stat_q;
		rsp_d       = rsp_q;
		rsp_load    = 1'b0;
		wr_en       = 1'b0;
		wr_addr     = '0;
		wr_data     = id_q;
		rd_en       = 1'b0;
		rd_addr     = '0;

		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					mode_d = req.mode;
					id_d   = req.chat_id[IDW-1:0];
					idx_d  = '0;
					chk_d  = 1'b0;
					case (req.mode)
						MODE_TOUCH, MODE_DELETE: begin
							state_d = ST_SCAN;
						end
						MODE_LIST: begin
							if (held_q != '0) begin
								state_d = ST_LIST_RD;
							end
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end

			ST_SCAN: begin
				if (match) begin
					chk_d   = 1'b0;
					dst_d   = chk_idx_q;
					pos_d   = chk_idx_q;
					state_d = ST_SH_RD;
					if (mode_q == MODE_TOUCH) begin
						front_d = 1'b1;
						stat_d  = STAT_MOVED;
					end else begin
						front_d = 1'b0;
						stat_d  = STAT_DELETED;
					end
				end else if (idx_q < held_q) begin
					rd_en     = 1'b1;
					rd_addr   = idx_q[AW-1:0];
					chk_idx_d = idx_q;
					chk_d     = 1'b1;
					idx_d     = idx_q + 1'b1;
				end else begin
					chk_d = 1'b0;
					pos_d = '0;
					if (mode_q == MODE_TOUCH) begin
						if (held_q == CW'(DEPTH)) begin
							stat_d  = STAT_FULL;
							state_d = ST_RESP;
						end else begin
							dst_d   = held_q;
							front_d = 1'b1;
							stat_d  = STAT_INSERTED;
							state_d = ST_SH_RD;
						end
					end else begin
						stat_d  = STAT_NOT_FOUND;
						state_d = ST_RESP;
					end
				end
			end

			ST_SH_RD: begin
				if (front_q) begin
					if (dst_q != '0) begin
						rd_en   = 1'b1;
						rd_addr = AW'(dst_q - 1'b1);
						state_d = ST_SH_WR;
					end else begin
						wr_en   = 1'b1;
						wr_addr = '0;
						wr_data = id_q;
						if (stat_q == STAT_INSERTED) begin
							held_d = held_q + 1'b1;
						end
						state_d = ST_RESP;
					end
				end else begin
					if ((dst_q + 1'b1) < held_q) begin
						rd_en   = 1'b1;
						rd_addr = AW'(dst_q + 1'b1);
						state_d = ST_SH_WR;
					end else begin
						held_d  = held_q - 1'b1;
						state_d = ST_RESP;
					end
				end
			end

			ST_SH_WR: begin
				wr_en   = 1'b1;
				wr_addr = dst_q[AW-1:0];
				wr_data = rd_data;
				dst_d   = front_q ? (dst_q - 1'b1) : (dst_q + 1'b1);
				state_d = ST_SH_RD;
			end

			ST_RESP: begin
				if (out_free) begin
					rsp_load          = 1'b1;
					rsp_d.status      = stat_q;
					rsp_d.entry_id    = ID_W'(id_q);
					rsp_d.rank        = (stat_q == STAT_DELETED) ? 4'(pos_q) : 4'd0;
					rsp_d.entry_count = 5'(held_q);
					rsp_d.last        = 1'b1;
					state_d           = ST_IDLE;
				end
			end

			ST_LIST_RD: begin
				rd_en   = 1'b1;
				rd_addr = idx_q[AW-1:0];
				state_d = ST_LIST_EM;
			end

			ST_LIST_EM: begin
				if (out_free) begin
					rsp_load          = 1'b1;
					rsp_d.status      = STAT_ENTRY;
					rsp_d.entry_id    = ID_W'(rd_data);
					rsp_d.rank        = 4'(idx_q);
					rsp_d.entry_count = 5'(held_q);
					rsp_d.last        = list_last;
					idx_d             = idx_q + 1'b1;
					state_d           = list_last ? ST_IDLE : ST_LIST_RD;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase

		rsp_valid_d = rsp_load ? 1'b1 : (rsp_valid_q && rsp_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			held_q      <= '0;
			chk_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			held_q      <= held_d;
			chk_q       <= chk_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		mode_q    <= mode_d;
		id_q      <= id_d;
		idx_q     <= idx_d;
		chk_idx_q <= chk_idx_d;
		dst_q     <= dst_d;
		pos_q     <= pos_d;
		front_q   <= front_d;
		stat_q    <= stat_d;
		rsp_q     <= rsp_d;
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### design/rol_mem.sv
// ----------------------------------------------------------------------------
// rol_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rol_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 16
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  logic [WIDTH-1:0]           wr_data,
	input  logic                       rd_en,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	output logic [WIDTH-1:0]           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
